>>> hw/rtl/tccs_pkg.sv
// Shared types, constants and helpers for the text console cursor/scroll block.
// No dependencies.
package tccs_pkg;

  localparam int ROWS   = 30;
  localparam int COLS   = 80;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_TOP   = 2'd2;

  localparam logic [7:0] CH_BS       = 8'd8;
  localparam logic [7:0] CH_NL       = 8'd10;
  localparam logic [7:0] CURSOR_MARK = 8'h5F;

  // One accepted byte, decoded: the character write, an optional scroll
  // (clear + new top), and the cursor mark.
  typedef struct packed {
    logic [ROW_W-1:0] row_c;
    logic [COL_W-1:0] col_c;
    logic [7:0]       data_c;
    logic             scroll;
    logic [ROW_W-1:0] clr_row;
    logic [ROW_W-1:0] top_new;
    logic [ROW_W-1:0] row_m;
    logic [COL_W-1:0] col_m;
  } tccs_cmd_t;

  // Both operands are below ROWS, so one conditional subtract wraps the sum.
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] line,
                                                input logic [ROW_W-1:0] top);
    logic [ROW_W:0] s;
    s = {1'b0, line} + {1'b0, top};
    if (s >= (ROW_W+1)'(ROWS)) s = s - (ROW_W+1)'(ROWS);
    return s[ROW_W-1:0];
  endfunction

endpackage

>>> hw/rtl/text_console_cursor_scroll.sv
// Top level of the text console cursor and ring-scroll command generator.
// Depends on tccs_pkg, tccs_front, tccs_fifo, tccs_back.

// Usage: feed one character byte per transfer on in_*; the block answers with
// character-memory commands on out_*, one command per cycle when out_ready is
// high. A byte yields two commands (cell write, then cursor mark 0x5F), or
// four when it pushes the cursor past the bottom line (cell write, clear of
// the old top row, new top offset, cursor mark); a backspace at the origin
// yields none. out_last flags the final command of each byte. The back-end
// sequencer that emits one command per cycle sets the sustained rate; the
// front end itself takes a byte every cycle while the queue is not full.
// The first command of a byte passes through the queue write, then the output
// register. A 4-entry queue decouples the two ends, so input transfers
// continue while results wait on out_ready.
module text_console_cursor_scroll (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_ch,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_op,
  output logic [tccs_pkg::ROW_W-1:0] out_row,
  output logic [tccs_pkg::COL_W-1:0] out_col,
  output logic [7:0]                 out_data,
  output logic                       out_last
);
  import tccs_pkg::*;

  // front -> queue
  logic      push;
  tccs_cmd_t push_cmd;
  logic      q_full;
  // queue -> back
  logic      head_valid;
  tccs_cmd_t head_cmd;
  logic      pop;

  // cursor/offset tracking and per-byte decode
  tccs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  tccs_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // command sequencer with registered output
  tccs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_op     (out_op),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_data   (out_data),
    .out_last   (out_last)
  );

`ifndef SYNTHESIS
  // clear and new-top commands never close a byte's command group
  a_scroll_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_op == OP_CLEAR || out_op == OP_TOP) |-> !out_last)
    else $error("scroll command flagged as last");

  // a row clear is always followed right away by the new top offset
  a_clear_then_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_op == OP_CLEAR |=> out_valid && out_op == OP_TOP)
    else $error("row clear not followed by top offset");

  // rows and offsets stay inside the ring
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_row < ROW_W'(ROWS))
    else $error("row outside ring");
`endif

endmodule

>>> hw/rtl/tccs_front.sv
// Front end: accepts character bytes, tracks cursor and ring offset, and
// builds at most one command descriptor per byte. Depends on tccs_pkg.
module tccs_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_ch,
  input  logic                q_full,
  output logic                push,
  output tccs_pkg::tccs_cmd_t push_cmd
);
  import tccs_pkg::*;

  logic [ROW_W-1:0] line_r, line_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] top_r, top_nxt;
  logic             acc, is_bs, is_nl, origin, wrap, scroll;
  logic [COL_W:0]   col_inc;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign is_bs    = (in_ch == CH_BS);
  assign is_nl    = (in_ch == CH_NL);
  assign origin   = (line_r == '0) && (col_r == '0);
  assign col_inc  = {1'b0, col_r} + (COL_W+1)'(1);
  assign wrap     = is_nl || (!is_bs && (col_inc >= (COL_W+1)'(COLS)));
  // backspace at the origin is swallowed
  assign push     = acc && !(is_bs && origin);

  always_comb begin
    line_nxt = line_r;
    col_nxt  = col_r;
    top_nxt  = top_r;
    scroll   = 1'b0;
    if (is_bs) begin
      if (col_r == '0) begin
        col_nxt  = COL_W'(COLS-1);
        line_nxt = line_r - ROW_W'(1);
      end else begin
        col_nxt = col_r - COL_W'(1);
      end
    end else if (wrap) begin
      col_nxt = '0;
      if (line_r >= ROW_W'(ROWS-1)) begin
        line_nxt = ROW_W'(ROWS-1);
        scroll   = 1'b1;
        top_nxt  = (top_r == ROW_W'(ROWS-1)) ? '0 : top_r + ROW_W'(1);
      end else begin
        line_nxt = line_r + ROW_W'(1);
      end
    end else begin
      col_nxt = col_inc[COL_W-1:0];
    end
  end

  always_comb begin
    push_cmd.row_c   = phys_row(line_r, top_r);
    push_cmd.col_c   = col_r;
    push_cmd.data_c  = is_bs ? 8'd0 : in_ch;
    push_cmd.scroll  = scroll;
    push_cmd.clr_row = top_r;
    push_cmd.top_new = top_nxt;
    push_cmd.row_m   = phys_row(line_nxt, top_nxt);
    push_cmd.col_m   = col_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r <= '0;
      col_r  <= '0;
      top_r  <= '0;
    end else if (push) begin
      line_r <= line_nxt;
      col_r  <= col_nxt;
      top_r  <= top_nxt;
    end
  end

endmodule

>>> hw/rtl/tccs_fifo.sv
// Short descriptor queue between front and back end.
// Depends on tccs_pkg.
module tccs_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tccs_pkg::tccs_cmd_t push_cmd,
  input  logic                pop,
  output logic                full,
  output logic                head_valid,
  output tccs_pkg::tccs_cmd_t head_cmd
);
  import tccs_pkg::*;

  tccs_cmd_t         q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;

  assign full       = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (QPTR_W+1)'(1);
        2'b01:   cnt_r <= cnt_r - (QPTR_W+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

>>> hw/rtl/tccs_back.sv
// Back end: walks each queued descriptor and issues its memory commands,
// one per cycle unless stalled, via an output register. Depends on tccs_pkg.
module tccs_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   head_valid,
  input  tccs_pkg::tccs_cmd_t    head_cmd,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_op,
  output logic [tccs_pkg::ROW_W-1:0] out_row,
  output logic [tccs_pkg::COL_W-1:0] out_col,
  output logic [7:0]             out_data,
  output logic                   out_last
);
  import tccs_pkg::*;

  typedef enum logic [1:0] {PH_CHAR, PH_CLR, PH_TOP, PH_MARK} phase_t;

  phase_t           phase_r;
  logic             out_valid_r;
  logic [1:0]       out_op_r;
  logic [ROW_W-1:0] out_row_r;
  logic [COL_W-1:0] out_col_r;
  logic [7:0]       out_data_r;
  logic             out_last_r;
  logic             load_ok, issue;

  assign load_ok = !out_valid_r || out_ready;
  assign issue   = head_valid && load_ok;
  assign pop     = issue && (phase_r == PH_MARK);

  assign out_valid = out_valid_r;
  assign out_op    = out_op_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_CHAR;
      out_valid_r <= 1'b0;
    end else begin
      if (load_ok) out_valid_r <= head_valid;
      if (issue) begin
        unique case (phase_r)
          PH_CHAR: begin
            out_op_r   <= OP_WRITE;
            out_row_r  <= head_cmd.row_c;
            out_col_r  <= head_cmd.col_c;
            out_data_r <= head_cmd.data_c;
            out_last_r <= 1'b0;
            phase_r    <= head_cmd.scroll ? PH_CLR : PH_MARK;
          end
          PH_CLR: begin
            out_op_r   <= OP_CLEAR;
            out_row_r  <= head_cmd.clr_row;
            out_col_r  <= '0;
            out_data_r <= 8'd0;
            out_last_r <= 1'b0;
            phase_r    <= PH_TOP;
          end
          PH_TOP: begin
            out_op_r   <= OP_TOP;
            out_row_r  <= head_cmd.top_new;
            out_col_r  <= '0;
            out_data_r <= 8'd0;
            out_last_r <= 1'b0;
            phase_r    <= PH_MARK;
          end
          PH_MARK: begin
            out_op_r   <= OP_WRITE;
            out_row_r  <= head_cmd.row_m;
            out_col_r  <= head_cmd.col_m;
            out_data_r <= CURSOR_MARK;
            out_last_r <= 1'b1;
            phase_r    <= PH_CHAR;
          end
          default: phase_r <= PH_CHAR;
        endcase
      end
    end
  end

endmodule
